[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty bodies when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define STT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define STT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// shared types, constants and keyword table of the source text tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

   localparam int KEYWORD_MAX_LEN = 8;
   localparam int KEYWORD_COUNT   = 8;
   localparam int KW_IDX_W        = 4;
   localparam int MAX_RESULTS     = 3;
   localparam int QUEUE_DEPTH     = 8;
   localparam int FILL_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [23:0] MAX24 = 24'hFF_FFFF;
   localparam logic [15:0] MAX16 = 16'hFFFF;
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_UNDER  = "_";
   localparam logic [7:0] CH_SEMI   = ";";
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_EQUAL  = "=";

   typedef enum logic [3:0] {
      TK_IDENT   = 4'd0,
      TK_KEYWORD = 4'd1,
      TK_NUMBER  = 4'd2,
      TK_SEMI    = 4'd3,
      TK_LPAREN  = 4'd4,
      TK_RPAREN  = 4'd5,
      TK_PLUS    = 4'd6,
      TK_STAR    = 4'd7,
      TK_MINUS   = 4'd8,
      TK_SLASH   = 4'd9,
      TK_EQUAL   = 4'd10,
      TK_END     = 4'd11,
      TK_BAD     = 4'd12
   } tok_kind_type;

   typedef enum logic [1:0] {
      SM_IDLE   = 2'd0,
      SM_IDENT  = 2'd1,
      SM_NUMBER = 2'd2,
      SM_DONE   = 2'd3
   } scan_mode_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [30:0]  value;
      logic [15:0]  length;
      logic [23:0]  offset;
      logic [23:0]  line;
      logic [15:0]  col;
      logic         last;
   } token_type;

   // tokens produced by one item, packed from slot 0
   typedef struct packed {
      logic [1:0]                       count;
      token_type [MAX_RESULTS-1:0]      item;
   } push_type;

   typedef struct packed {
      logic              valid;
      logic              room;
      logic [FILL_W-1:0] fill;
   } q_status_type;

   // keyword lengths, zero for unused table slots
   function automatic int unsigned kw_len(input int unsigned idx);
      int unsigned n;
      case (idx)
         0, 1:    n = 2;
         2, 3, 4: n = 3;
         5:       n = 5;
         6:       n = 6;
         7:       n = 8;
         default: n = 0;
      endcase
      return n;
   endfunction

   // character pos of keyword idx
   function automatic logic [7:0] kw_byte(input int unsigned idx, input int unsigned pos);
      logic [127:0] w;
      int unsigned  n;
      w = '0;
      n = kw_len(idx);
      case (idx)
         0:       w = 128'("to");
         1:       w = 128'("if");
         2:       w = 128'("end");
         3:       w = 128'("for");
         4:       w = 128'("var");
         5:       w = 128'("begin");
         6:       w = 128'("return");
         7:       w = 128'("function");
         default: w = '0;
      endcase
      if (pos < n) begin
         return w[8*(n-1-pos) +: 8];
      end
      return 8'h00;
   endfunction

endpackage

`default_nettype wire

[rtl/stt_req_if.sv]
// ----------------------------------------------------------------------------
// stt_req_if
// byte channel into the tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       is_last;

   modport source (output valid, output char_byte, output is_last, input ready);
   modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

`default_nettype wire

[rtl/stt_rsp_if.sv]
// ----------------------------------------------------------------------------
// stt_rsp_if
// token channel out of the tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [30:0] token_value;
   logic [15:0] token_length;
   logic [23:0] token_offset;
   logic [23:0] token_line;
   logic [15:0] token_col;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_value, output token_length,
                   output token_offset, output token_line, output token_col,
                   output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_value, input token_length,
                   input token_offset, input token_line, input token_col,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/stt_keyword_match.sv]
// ----------------------------------------------------------------------------
// stt_keyword_match
// parallel compare of an identifier prefix against the keyword table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stt_keyword_match #(
   parameter int KEYWORD_MAX_LEN = stt_pkg::KEYWORD_MAX_LEN,
   parameter int KEYWORD_COUNT   = stt_pkg::KEYWORD_COUNT
) (
   input  logic [KEYWORD_MAX_LEN-1:0][7:0] prefix,
   input  logic [15:0]                     length,
   output logic                            hit,
   output logic [stt_pkg::KW_IDX_W-1:0]    index
);

   // lowest index wins
   always_comb begin
      logic ok;
      hit   = 1'b0;
      index = '0;
      for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
         ok = (length == 16'(stt_pkg::kw_len(unsigned'(i))));
         for (int k = 0; k < KEYWORD_MAX_LEN; k++) begin
            if (unsigned'(k) < stt_pkg::kw_len(unsigned'(i)) &&
                prefix[k] != stt_pkg::kw_byte(unsigned'(i), unsigned'(k))) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            hit   = 1'b1;
            index = stt_pkg::KW_IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/stt_scanner.sv]
// ----------------------------------------------------------------------------
// stt_scanner
// scan state, position counters and token building for one byte per cycle while fire is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stt_scanner #(
   parameter int KEYWORD_MAX_LEN = stt_pkg::KEYWORD_MAX_LEN,
   parameter int KEYWORD_COUNT   = stt_pkg::KEYWORD_COUNT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             char_byte,
   input  logic                   is_last,
   output stt_pkg::push_type      push,
   output stt_pkg::scan_mode_type mode
);

   localparam int PFX_IDX_W = $clog2(KEYWORD_MAX_LEN);

   stt_pkg::scan_mode_type mode_ff, mode_in, p_mode;
   logic [23:0] offset_ff, offset_in, p_offset;
   logic [23:0] line_ff, line_in, p_line;
   logic [15:0] col_ff, col_in, p_col;
   logic [23:0] soff_ff, soff_in, p_soff;
   logic [23:0] sline_ff, sline_in, p_sline;
   logic [15:0] scol_ff, scol_in, p_scol;
   logic [15:0] len_ff, len_in, p_len;
   logic [30:0] acc_ff, acc_in, p_acc;
   logic [KEYWORD_MAX_LEN-1:0][7:0] prefix_ff, prefix_in, p_prefix;

   logic is_alpha, is_digit, is_space, is_nul, extend;
   stt_pkg::tok_kind_type op_kind;
   logic [23:0] adv_offset, adv_line, bad_line;
   logic [15:0] adv_col, len_sat;
   logic [34:0] acc_x10;
   logic [30:0] acc_next;
   logic [PFX_IDX_W-1:0] pfx_idx;

   logic have_a, have_b, want_tail, restart;
   stt_pkg::token_type tok_b;
   stt_pkg::token_type cand [4];
   logic [3:0] have;
   logic [1:0] n;

   logic cur_hit, nxt_hit;
   logic [stt_pkg::KW_IDX_W-1:0] cur_idx, nxt_idx;

   assign mode = mode_ff;

   // byte classes
   assign is_alpha = (char_byte >= "A" && char_byte <= "Z") ||
                     (char_byte >= "a" && char_byte <= "z");
   assign is_digit = char_byte >= "0" && char_byte <= "9";
   assign is_space = char_byte inside {stt_pkg::CH_SPACE, stt_pkg::CH_TAB,
                                       stt_pkg::CH_CR, stt_pkg::CH_LF};
   assign is_nul   = char_byte == stt_pkg::CH_NUL;
   assign extend   = (mode_ff == stt_pkg::SM_IDENT &&
                      (is_alpha || is_digit || char_byte == stt_pkg::CH_UNDER)) ||
                     (mode_ff == stt_pkg::SM_NUMBER && is_digit);

   always_comb begin
      case (char_byte)
         stt_pkg::CH_SEMI:   op_kind = stt_pkg::TK_SEMI;
         stt_pkg::CH_LPAREN: op_kind = stt_pkg::TK_LPAREN;
         stt_pkg::CH_RPAREN: op_kind = stt_pkg::TK_RPAREN;
         stt_pkg::CH_PLUS:   op_kind = stt_pkg::TK_PLUS;
         stt_pkg::CH_STAR:   op_kind = stt_pkg::TK_STAR;
         stt_pkg::CH_MINUS:  op_kind = stt_pkg::TK_MINUS;
         stt_pkg::CH_SLASH:  op_kind = stt_pkg::TK_SLASH;
         stt_pkg::CH_EQUAL:  op_kind = stt_pkg::TK_EQUAL;
         default:            op_kind = stt_pkg::TK_IDENT;
      endcase
   end

   // saturating position update
   assign adv_offset = (offset_ff == stt_pkg::MAX24) ? offset_ff : offset_ff + 24'd1;
   assign bad_line   = (line_ff == stt_pkg::MAX24) ? line_ff : line_ff + 24'd1;
   assign adv_line   = (char_byte == stt_pkg::CH_LF) ? bad_line : line_ff;
   assign adv_col    = (char_byte == stt_pkg::CH_LF) ? 16'd0 :
                       (col_ff == stt_pkg::MAX16) ? col_ff : col_ff + 16'd1;
   assign len_sat    = (len_ff == stt_pkg::MAX16) ? len_ff : len_ff + 16'd1;
   assign pfx_idx    = len_ff[PFX_IDX_W-1:0];

   // acc * 10 + digit, clamped
   assign acc_x10  = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {31'b0, char_byte[3:0]};
   assign acc_next = (acc_x10 > {4'b0, stt_pkg::MAX31}) ? stt_pkg::MAX31 : acc_x10[30:0];

   // next state and the first two token candidates
   always_comb begin
      p_mode    = mode_ff;
      p_offset  = offset_ff;
      p_line    = line_ff;
      p_col     = col_ff;
      p_soff    = soff_ff;
      p_sline   = sline_ff;
      p_scol    = scol_ff;
      p_len     = len_ff;
      p_acc     = acc_ff;
      p_prefix  = prefix_ff;
      have_a    = 1'b0;
      have_b    = 1'b0;
      want_tail = 1'b0;
      restart   = 1'b0;
      tok_b     = '0;
      if (fire) begin
         if (mode_ff == stt_pkg::SM_DONE) begin
            restart = is_last;
         end else if (extend) begin
            p_len = len_sat;
            if (len_ff < 16'(KEYWORD_MAX_LEN)) begin
               p_prefix[pfx_idx] = char_byte;
            end
            if (mode_ff == stt_pkg::SM_NUMBER) begin
               p_acc = acc_next;
            end
            p_offset  = adv_offset;
            p_line    = adv_line;
            p_col     = adv_col;
            want_tail = is_last;
            restart   = is_last;
         end else begin
            have_a = (mode_ff == stt_pkg::SM_IDENT) || (mode_ff == stt_pkg::SM_NUMBER);
            p_mode = stt_pkg::SM_IDLE;
            if (is_nul) begin
               have_b     = 1'b1;
               tok_b.kind = stt_pkg::TK_END;
               restart    = is_last;
               if (!is_last) begin
                  p_mode = stt_pkg::SM_DONE;
               end
            end else begin
               p_offset = adv_offset;
               p_line   = adv_line;
               p_col    = adv_col;
               if (op_kind != stt_pkg::TK_IDENT) begin
                  have_b       = 1'b1;
                  tok_b.kind   = op_kind;
                  tok_b.length = 16'd1;
                  tok_b.offset = offset_ff;
                  tok_b.line   = line_ff;
                  tok_b.col    = col_ff;
               end else if (is_alpha || is_digit) begin
                  p_mode  = is_alpha ? stt_pkg::SM_IDENT : stt_pkg::SM_NUMBER;
                  p_soff  = offset_ff;
                  p_sline = line_ff;
                  p_scol  = col_ff;
                  p_len   = 16'd1;
                  p_acc   = {27'b0, char_byte[3:0]};
                  p_prefix[0] = char_byte;
               end else if (!is_space) begin
                  have_b       = 1'b1;
                  tok_b.kind   = stt_pkg::TK_BAD;
                  tok_b.value  = {23'b0, char_byte};
                  tok_b.length = 16'd1;
                  tok_b.offset = offset_ff;
                  tok_b.line   = bad_line;
                  tok_b.col    = col_ff;
               end
               want_tail = is_last;
               restart   = is_last;
            end
         end
      end
      mode_in   = restart ? stt_pkg::SM_IDLE : p_mode;
      offset_in = restart ? 24'd0 : p_offset;
      line_in   = restart ? 24'd0 : p_line;
      col_in    = restart ? 16'd0 : p_col;
      soff_in   = restart ? 24'd0 : p_soff;
      sline_in  = restart ? 24'd0 : p_sline;
      scol_in   = restart ? 16'd0 : p_scol;
      len_in    = restart ? 16'd0 : p_len;
      acc_in    = restart ? 31'd0 : p_acc;
      prefix_in = p_prefix;
   end

   stt_keyword_match #(
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .KEYWORD_COUNT   (KEYWORD_COUNT)
   ) u_match_cur (
      .prefix (prefix_ff),
      .length (len_ff),
      .hit    (cur_hit),
      .index  (cur_idx)
   );

   stt_keyword_match #(
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .KEYWORD_COUNT   (KEYWORD_COUNT)
   ) u_match_nxt (
      .prefix (p_prefix),
      .length (p_len),
      .hit    (nxt_hit),
      .index  (nxt_idx)
   );

   // token candidates in emission order, then packed into slots
   always_comb begin
      cand[0] = '0;
      cand[0].kind   = (mode_ff == stt_pkg::SM_NUMBER) ? stt_pkg::TK_NUMBER :
                       cur_hit ? stt_pkg::TK_KEYWORD : stt_pkg::TK_IDENT;
      cand[0].value  = (mode_ff == stt_pkg::SM_NUMBER) ? acc_ff :
                       cur_hit ? 31'(cur_idx) : 31'd0;
      cand[0].length = len_ff;
      cand[0].offset = soff_ff;
      cand[0].line   = sline_ff;
      cand[0].col    = scol_ff;
      cand[1] = tok_b;
      cand[2] = '0;
      cand[2].kind   = (p_mode == stt_pkg::SM_NUMBER) ? stt_pkg::TK_NUMBER :
                       nxt_hit ? stt_pkg::TK_KEYWORD : stt_pkg::TK_IDENT;
      cand[2].value  = (p_mode == stt_pkg::SM_NUMBER) ? p_acc :
                       nxt_hit ? 31'(nxt_idx) : 31'd0;
      cand[2].length = p_len;
      cand[2].offset = p_soff;
      cand[2].line   = p_sline;
      cand[2].col    = p_scol;
      cand[3] = '0;
      cand[3].kind   = stt_pkg::TK_END;
      have = {want_tail,
              want_tail && (p_mode == stt_pkg::SM_IDENT || p_mode == stt_pkg::SM_NUMBER),
              have_b, have_a};
      push = '0;
      n    = 2'd0;
      for (int j = 0; j < 4; j++) begin
         if (have[j]) begin
            push.item[n] = cand[j];
            n = n + 2'd1;
         end
      end
      if (n != 2'd0) begin
         push.item[n - 2'd1].last = 1'b1;
      end
      push.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stt_pkg::SM_IDLE;
         offset_ff <= '0;
         line_ff   <= '0;
         col_ff    <= '0;
         soff_ff   <= '0;
         sline_ff  <= '0;
         scol_ff   <= '0;
         len_ff    <= '0;
         acc_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         offset_ff <= offset_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         soff_ff   <= soff_in;
         sline_ff  <= sline_in;
         scol_ff   <= scol_in;
         len_ff    <= len_in;
         acc_ff    <= acc_in;
      end
   end

   // identifier head bytes, only read where written
   always_ff @(posedge clock) begin
      prefix_ff <= prefix_in;
   end

endmodule

`default_nettype wire

[rtl/stt_result_queue.sv]
// ----------------------------------------------------------------------------
// stt_result_queue
// token queue, up to three writes and one read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stt_result_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  stt_pkg::push_type     push,
   input  logic                  pop,
   output stt_pkg::token_type    head,
   output stt_pkg::q_status_type status
);

   localparam int PTR_W = $clog2(stt_pkg::QUEUE_DEPTH);
   localparam int CNT_W = stt_pkg::FILL_W;

   stt_pkg::token_type mem [stt_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             pop_ok;

   assign pop_ok    = pop && (fill_ff != '0);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop_ok);
   assign fill_in   = fill_ff + CNT_W'(push.count) - CNT_W'(pop_ok);

   assign head         = mem[rd_ptr_ff];
   assign status.valid = fill_ff != '0;
   assign status.room  = fill_ff <= CNT_W'(stt_pkg::QUEUE_DEPTH - stt_pkg::MAX_RESULTS);
   assign status.fill  = fill_ff;

   always_ff @(posedge clock) begin
      for (int j = 0; j < stt_pkg::MAX_RESULTS; j++) begin
         if (2'(j) < push.count) begin
            mem[wr_ptr_ff + PTR_W'(j)] <= push.item[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

[rtl/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer
// byte-stream lexer: identifiers, keywords, numbers, operators, end token
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one source byte per item plus an is_last flag; rsp_chan
//   carries one token per item with kind, value, length, start position and
//   a last_of_run flag on the final token caused by a byte.
//   a byte is scanned in the cycle it is accepted and its tokens (zero to
//   three) are written into an 8-entry result queue at that same edge, so the
//   queue is the only register between an accepted byte and rsp_chan.
//   req_chan takes one byte per cycle as long as the queue has three free
//   entries; rsp_chan drains one token per cycle, so the sustained byte rate
//   is one per cycle when bytes average at most one token each, and is
//   otherwise set by the single read port of the result queue.
//   when the receiver stalls, tokens collect in the queue and req_chan.ready
//   drops once fewer than three entries are free; nothing is lost.
//   reset clears the scan mode, position counters and queue; the identifier
//   prefix store is not cleared, it is only read where written.
//   after a NUL byte, bytes are swallowed until one flagged is_last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module source_text_tokenizer #(
   parameter int KEYWORD_MAX_LEN = stt_pkg::KEYWORD_MAX_LEN,
   parameter int KEYWORD_COUNT   = stt_pkg::KEYWORD_COUNT
) (
   input  logic      clock,
   input  logic      reset,
   stt_req_if.sink   req_chan,
   stt_rsp_if.source rsp_chan
);

   // byte and token handshakes
   logic req_fire;
   logic rsp_fire;

   // scanner to queue
   stt_pkg::push_type      push;
   stt_pkg::scan_mode_type scan_mode;

   // queue head and status
   stt_pkg::token_type    head;
   stt_pkg::q_status_type q_stat;

   // accept only with room for the worst-case three tokens
   assign req_chan.ready = q_stat.room;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   // scan state, counters and token assembly
   stt_scanner #(
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .KEYWORD_COUNT   (KEYWORD_COUNT)
   ) u_scanner (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .char_byte (req_chan.char_byte),
      .is_last   (req_chan.is_last),
      .push      (push),
      .mode      (scan_mode)
   );

   // token queue, also the output register stage
   stt_result_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_fire),
      .head   (head),
      .status (q_stat)
   );

   // token fields to the output channel
   assign rsp_chan.valid        = q_stat.valid;
   assign rsp_chan.token_kind   = head.kind;
   assign rsp_chan.token_value  = head.value;
   assign rsp_chan.token_length = head.length;
   assign rsp_chan.token_offset = head.offset;
   assign rsp_chan.token_line   = head.line;
   assign rsp_chan.token_col    = head.col;
   assign rsp_chan.last_of_run  = head.last;

   // a text end always yields at least the end token on the next cycle
   `STT_ASSERT_NEXT(a_end_emits, clock, reset,
      req_fire && scan_mode != stt_pkg::SM_DONE &&
         (req_chan.is_last || req_chan.char_byte == stt_pkg::CH_NUL),
      rsp_chan.valid, "end of text produced no token")

   // the end token closes its run
   `STT_ASSERT_IMPLY(a_end_is_last, clock, reset,
      rsp_chan.valid && rsp_chan.token_kind == stt_pkg::TK_END,
      rsp_chan.last_of_run, "end token not flagged last of run")

   // the rest of a run is queued with its first token
   `STT_ASSERT_IMPLY(a_run_queued, clock, reset,
      rsp_chan.valid && !rsp_chan.last_of_run,
      q_stat.fill >= stt_pkg::FILL_W'(2), "run split across queue writes")

endmodule

`default_nettype wire

[tb/source_text_tokenizer_test.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_test
// self-checking bench for the byte-stream lexer: a directed table of bytes
// with hand-written tokens where they are obvious, then random source texts
// built from keywords, identifiers, numbers, operators, blanks and noise,
// all checked token by token against a lexer written into the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module source_text_tokenizer_test;
   import stt_pkg::*;

   localparam int RESET_CYCLES    = 9;
   localparam int STUCK_LIMIT     = 2000;   // cycles with no handshake on either side
   localparam int SETTLE_CYCLES   = 20;
   localparam int REPORT_LIMIT    = 10;
   localparam int BYTES_PER_PHASE = 111;

   // one row of the directed table; tok is used only where typed is set
   typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       typed;
      token_type  tok;
   } text_row_type;

   logic clock = 1'b0;
   logic reset;

   stt_req_if req_chan ();
   stt_rsp_if rsp_chan ();

   source_text_tokenizer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // directed table
   // ---------------------------------------------------------------------
   text_row_type directed_text [26] = '{
      // first bytes after reset: bad chars carry a one-based line
      '{"@",    1'b0, 1'b1, '{TK_BAD,  31'h40, 16'd1, 24'd0, 24'd1, 16'd0, 1'b1}},
      '{8'hFF,  1'b0, 1'b1, '{TK_BAD,  31'hFF, 16'd1, 24'd1, 24'd1, 16'd1, 1'b1}},
      // leading underscore is not an identifier start
      '{"_",    1'b0, 1'b1, '{TK_BAD,  31'h5F, 16'd1, 24'd2, 24'd1, 16'd2, 1'b1}},
      '{";",    1'b0, 1'b1, '{TK_SEMI, 31'd0,  16'd1, 24'd3, 24'd0, 16'd3, 1'b1}},
      '{CH_LF,  1'b0, 1'b0, '0},
      // number ended by a letter: number first, then the identifier
      '{"1",    1'b0, 1'b0, '0},
      '{"2",    1'b0, 1'b0, '0},
      '{"a",    1'b0, 1'b0, '0},
      '{"(",    1'b0, 1'b0, '0},
      '{")",    1'b0, 1'b0, '0},
      // keyword ended by an operator
      '{"i",    1'b0, 1'b0, '0},
      '{"f",    1'b0, 1'b0, '0},
      '{"+",    1'b0, 1'b0, '0},
      '{"*",    1'b0, 1'b0, '0},
      '{"-",    1'b0, 1'b0, '0},
      '{"/",    1'b0, 1'b0, '0},
      '{"9",    1'b0, 1'b0, '0},
      '{"=",    1'b0, 1'b0, '0},
      // nul flushes the pending identifier, then swallows until a last byte
      '{"x",    1'b0, 1'b0, '0},
      '{CH_NUL, 1'b0, 1'b0, '0},
      '{"q",    1'b0, 1'b0, '0},
      '{CH_TAB, 1'b1, 1'b0, '0},
      // last byte completes a keyword: keyword then end token
      '{"e",    1'b0, 1'b0, '0},
      '{"n",    1'b0, 1'b0, '0},
      '{"d",    1'b1, 1'b0, '0},
      // nul flagged last on a fresh text: a lone end token
      '{CH_NUL, 1'b1, 1'b1, '{TK_END,  31'd0,  16'd0, 24'd0, 24'd0, 16'd0, 1'b1}}
   };

   string      keyword_text [KEYWORD_COUNT] =
      '{"to", "if", "end", "for", "var", "begin", "return", "function"};
   logic [7:0] operator_char [8] =
      '{CH_SEMI, CH_LPAREN, CH_RPAREN, CH_PLUS, CH_STAR, CH_MINUS, CH_SLASH, CH_EQUAL};
   logic [7:0] blank_char [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

   // idle percentages per phase: none, sender, receiver, both
   int phase_send_idle [4] = '{0, 79, 0, 18};
   int phase_stall     [4] = '{0, 0, 79, 18};
   int send_idle_pct = 0;
   int stall_pct     = 0;

   int error_count  = 0;
   int stuck_cycles = 0;

   // ---------------------------------------------------------------------
   // lexer state mirrored by the bench
   // ---------------------------------------------------------------------
   scan_mode_type lex_mode;
   logic [23:0]   at_offset, at_line, word_offset, word_line;
   logic [15:0]   at_col, word_col, word_len;
   logic [30:0]   number_value;
   logic [7:0]    word_head [KEYWORD_MAX_LEN];
   token_type     byte_tokens [$];     // tokens caused by the byte just taken
   token_type     awaited_tokens [$];  // tokens still to come out, oldest first

   function automatic bit is_letter(logic [7:0] ch);
      return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
   endfunction

   function automatic bit is_digit(logic [7:0] ch);
      return ch >= 8'h30 && ch <= 8'h39;
   endfunction

   // back to the start of a text
   function automatic void rewind_text();
      lex_mode     = SM_IDLE;
      at_offset    = '0;
      at_line      = '0;
      at_col       = '0;
      word_offset  = '0;
      word_line    = '0;
      word_col     = '0;
      word_len     = '0;
      number_value = '0;
   endfunction

   function automatic void add_token(tok_kind_type kind, logic [30:0] value,
                                     logic [15:0] len, logic [23:0] off,
                                     logic [23:0] line, logic [15:0] col);
      token_type t;
      t.kind   = kind;
      t.value  = value;
      t.length = len;
      t.offset = off;
      t.line   = line;
      t.col    = col;
      t.last   = 1'b0;
      byte_tokens.push_back(t);
   endfunction

   // position counters, all saturating
   function automatic void move_past(logic [7:0] ch);
      if (at_offset != MAX24) at_offset++;
      if (ch == CH_LF) begin
         at_col = '0;
         if (at_line != MAX24) at_line++;
      end else if (at_col != MAX16) begin
         at_col++;
      end
   endfunction

   function automatic void start_word();
      word_offset = at_offset;
      word_line   = at_line;
      word_col    = at_col;
      word_len    = 16'd1;
   endfunction

   // index of the keyword the pending identifier spells, or -1
   function automatic int keyword_index();
      int  i;
      int  k;
      bit  same;
      if (word_len > KEYWORD_MAX_LEN) return -1;
      for (i = 0; i < KEYWORD_COUNT; i++) begin
         if (keyword_text[i].len() == word_len) begin
            same = 1'b1;
            for (k = 0; k < word_len; k++) begin
               if (word_head[k] != keyword_text[i][k]) same = 1'b0;
            end
            if (same) return i;
         end
      end
      return -1;
   endfunction

   // emit the pending identifier or number, if any
   function automatic void close_word();
      int kw;
      if (lex_mode == SM_IDENT) begin
         kw = keyword_index();
         if (kw < 0) begin
            add_token(TK_IDENT, '0, word_len, word_offset, word_line, word_col);
         end else begin
            add_token(TK_KEYWORD, 31'(kw), word_len, word_offset, word_line, word_col);
         end
      end else if (lex_mode == SM_NUMBER) begin
         add_token(TK_NUMBER, number_value, word_len, word_offset, word_line, word_col);
      end
      lex_mode = SM_IDLE;
   endfunction

   // one byte through the lexer; tokens land in byte_tokens
   function automatic void lex_byte(logic [7:0] ch, logic last);
      bit           taken;
      bit           is_op;
      logic [63:0]  grown;
      tok_kind_type op;
      token_type    closing;
      taken = 1'b0;
      is_op = 1'b1;
      op    = TK_IDENT;
      byte_tokens.delete();

      // after a nul everything is swallowed; a last byte starts a new text
      if (lex_mode == SM_DONE) begin
         if (last) rewind_text();
         return;
      end

      if (lex_mode == SM_IDENT) begin
         if (is_letter(ch) || is_digit(ch) || ch == CH_UNDER) begin
            if (word_len < KEYWORD_MAX_LEN) word_head[word_len] = ch;
            if (word_len != MAX16) word_len++;
            move_past(ch);
            taken = 1'b1;
         end else begin
            close_word();
         end
      end else if (lex_mode == SM_NUMBER) begin
         if (is_digit(ch)) begin
            grown = number_value * 64'd10 + ch - 8'h30;
            number_value = (grown > MAX31) ? MAX31 : grown[30:0];
            if (word_len != MAX16) word_len++;
            move_past(ch);
            taken = 1'b1;
         end else begin
            close_word();
         end
      end

      if (!taken && ch == CH_NUL) begin
         // nul is not consumed and ends the text here
         add_token(TK_END, '0, '0, '0, '0, '0);
         if (last) rewind_text();
         else lex_mode = SM_DONE;
      end else begin
         if (!taken) begin
            case (ch)
               CH_SEMI:   op = TK_SEMI;
               CH_LPAREN: op = TK_LPAREN;
               CH_RPAREN: op = TK_RPAREN;
               CH_PLUS:   op = TK_PLUS;
               CH_STAR:   op = TK_STAR;
               CH_MINUS:  op = TK_MINUS;
               CH_SLASH:  op = TK_SLASH;
               CH_EQUAL:  op = TK_EQUAL;
               default:   is_op = 1'b0;
            endcase
            if (is_op) begin
               add_token(op, '0, 16'd1, at_offset, at_line, at_col);
            end else if (is_letter(ch)) begin
               start_word();
               word_head[0] = ch;
               lex_mode = SM_IDENT;
            end else if (is_digit(ch)) begin
               start_word();
               number_value = 31'(ch - 8'h30);
               lex_mode = SM_NUMBER;
            end else if (ch != CH_SPACE && ch != CH_TAB && ch != CH_CR && ch != CH_LF) begin
               add_token(TK_BAD, 31'(ch), 16'd1, at_offset,
                         (at_line == MAX24) ? MAX24 : at_line + 24'd1, at_col);
            end
            move_past(ch);
         end
         if (last) begin
            close_word();
            add_token(TK_END, '0, '0, '0, '0, '0);
            rewind_text();
         end
      end

      // flag the final token of this byte
      if (byte_tokens.size() > 0) begin
         closing = byte_tokens.pop_back();
         closing.last = 1'b1;
         byte_tokens.push_back(closing);
      end
   endfunction

   // ---------------------------------------------------------------------
   // token checking
   // ---------------------------------------------------------------------
   function automatic string token_text(token_type t);
      return $sformatf("kind %0d value %0d len %0d off %0d line %0d col %0d last %0b",
                       t.kind, t.value, t.length, t.offset, t.line, t.col, t.last);
   endfunction

   function automatic void check_token();
      token_type seen;
      token_type want;
      seen.kind   = tok_kind_type'(rsp_chan.token_kind);
      seen.value  = rsp_chan.token_value;
      seen.length = rsp_chan.token_length;
      seen.offset = rsp_chan.token_offset;
      seen.line   = rsp_chan.token_line;
      seen.col    = rsp_chan.token_col;
      seen.last   = rsp_chan.last_of_run;
      if (awaited_tokens.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("token with nothing awaited: %s", token_text(seen));
         end
      end else begin
         want = awaited_tokens.pop_front();
         if (seen.kind !== want.kind || seen.value !== want.value ||
             seen.length !== want.length || seen.offset !== want.offset ||
             seen.line !== want.line || seen.col !== want.col || seen.last !== want.last) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("token mismatch");
               $display("  expected %s", token_text(want));
               $display("  actual   %s", token_text(seen));
            end
         end
      end
   endfunction

   // receiver: check each accepted token, stall at the phase's rate
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_token();
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // watchdog: cycles in which no item moves on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // byte sender
   // ---------------------------------------------------------------------
   // valid stays high from one item to the next unless a gap is drawn, so
   // it never gets two assignments in one step
   task automatic send_byte(input logic [7:0] ch, input logic last,
                            input logic typed = 1'b0, input token_type typed_tok = '0);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_byte <= ch;
      req_chan.is_last   <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // taken at this edge
      lex_byte(ch, last);
      if (typed) begin
         awaited_tokens.push_back(typed_tok);
      end else begin
         foreach (byte_tokens[j]) awaited_tokens.push_back(byte_tokens[j]);
      end
   endtask

   function automatic logic [7:0] random_letter();
      if ($urandom_range(0, 1)) return 8'($urandom_range(8'h41, 8'h5A));
      return 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   function automatic logic [7:0] random_word_char();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(8'h41, 8'h5A));
         1:       return 8'($urandom_range(8'h61, 8'h7A));
         2:       return 8'($urandom_range(8'h30, 8'h39));
         default: return CH_UNDER;
      endcase
   endfunction

   // one random source text, mostly well-formed, with its own ending;
   // bytes swallowed after a nul are not counted
   task automatic send_random_text(inout int counted);
      logic [7:0] text [$];
      int         piece;
      int         pieces;
      int         k;
      int         pick;
      int         ending;
      string      word;
      pieces = $urandom_range(1, 12);
      for (piece = 0; piece < pieces; piece++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            // keyword, sometimes grown into a longer identifier
            word = keyword_text[$urandom_range(0, KEYWORD_COUNT - 1)];
            for (k = 0; k < word.len(); k++) text.push_back(word[k]);
            if ($urandom_range(0, 3) == 0) text.push_back(random_word_char());
         end else if (pick < 40) begin
            text.push_back(random_letter());
            repeat ($urandom_range(0, ($urandom_range(0, 9) == 0) ? 12 : 4))
               text.push_back(random_word_char());
         end else if (pick < 55) begin
            // long runs saturate the value
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 14 : 4))
               text.push_back(8'($urandom_range(8'h30, 8'h39)));
         end else if (pick < 75) begin
            text.push_back(operator_char[$urandom_range(0, 7)]);
         end else if (pick < 90) begin
            text.push_back(blank_char[$urandom_range(0, 3)]);
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
         // keep neighbours apart most of the time
         if ($urandom_range(0, 1)) text.push_back(blank_char[$urandom_range(0, 3)]);
      end

      ending = $urandom_range(0, 9);
      for (k = 0; k < text.size(); k++) begin
         send_byte(text[k], (ending < 5) && (k == text.size() - 1));
      end
      counted += text.size();
      if (ending >= 5 && ending < 8) begin
         // nul, some swallowed bytes, then a last byte to start over
         send_byte(CH_NUL, 1'b0);
         repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
         counted += 1;
      end else if (ending >= 8) begin
         send_byte(CH_NUL, 1'b1);
         counted += 1;
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int phase;
      int counted;
      rewind_text();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_byte = '0;
      req_chan.is_last   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_text[r]) begin
         send_byte(directed_text[r].ch, directed_text[r].last,
                   directed_text[r].typed, directed_text[r].tok);
      end

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = phase_send_idle[phase];
         stall_pct     = phase_stall[phase];
         counted       = 0;
         while (counted < BYTES_PER_PHASE) send_random_text(counted);
      end
      req_chan.valid <= 1'b0;

      // drain, then settle so that anything stray shows up
      while (awaited_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && awaited_tokens.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
